/* hw/rtl/imh_pkg.sv */
// Package for the indexed min-heap: opcodes, status codes, register indexes.
// No dependencies; used by indexed_min_heap.
package imh_pkg;

	localparam int unsigned CAPACITY_DEFAULT  = 256;
	localparam int unsigned KEY_WIDTH_DEFAULT = 32;
	localparam int unsigned CFG_IDX_W         = 1;
	localparam int unsigned CFG_DATA_W        = 9;

	localparam logic [1:0] FUNC_INSERT   = 2'd0;
	localparam logic [1:0] FUNC_EXTRACT  = 2'd1;
	localparam logic [1:0] FUNC_DECREASE = 2'd2;
	localparam logic [1:0] FUNC_PEEK     = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_EMPTY      = 3'd1;
	localparam logic [2:0] ST_FULL       = 3'd2;
	localparam logic [2:0] ST_BAD_HANDLE = 3'd3;
	localparam logic [2:0] ST_LARGER     = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED_KEYS    = 1'd1;

endpackage

/* hw/rtl/indexed_min_heap.sv */
// Indexed binary min-heap: top level with sequencer, flags and output register.
// Depends on imh_pkg, imh_heap_mem and imh_elem_mem.
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | func, handle, key
//  out     | out_valid / out_ready| result_key, result_handle, status, element_count
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// One item at a time: a word is accepted only in S_IDLE. Insert and decrease
// climb through S_U1 to S_U3 per level, extract descends through S_D1 to S_D4
// per level. Each heap step uses registered reads of both memories.
// Reset clears count and in-heap flags at once; no clearing pass.
// A held result does not block the next word from being accepted, but the
// sequencer waits at the end of that word until the output register is free.
module indexed_min_heap #(
	parameter int unsigned CAPACITY  = imh_pkg::CAPACITY_DEFAULT,
	parameter int unsigned KEY_WIDTH = imh_pkg::KEY_WIDTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       func,
	input  logic [7:0]                       handle,
	input  logic [31:0]                      key,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [31:0]                      result_key,
	output logic [7:0]                       result_handle,
	output logic [2:0]                       status,
	output logic [8:0]                       element_count,
	input  logic                             cfg_we,
	input  logic [imh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [imh_pkg::CFG_DATA_W-1:0]   cfg_data
);
	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned EW = KEY_WIDTH + AW;
	localparam int unsigned KL = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_RD    = 14'b00000000000010,
		S_CHK   = 14'b00000000000100,
		S_X1    = 14'b00000000001000,
		S_X2    = 14'b00000000010000,
		S_U1    = 14'b00000000100000,
		S_U2    = 14'b00000001000000,
		S_U3    = 14'b00000010000000,
		S_D1    = 14'b00000100000000,
		S_D2    = 14'b00001000000000,
		S_D3    = 14'b00010000000000,
		S_D4    = 14'b00100000000000,
		S_F     = 14'b01000000000000,
		S_DONE  = 14'b10000000000000
	} state_t;

	state_t state_q;
	logic [8:0] cap_q;
	logic sgn_q;
	logic [CW-1:0] count_q;
	logic [CAPACITY-1:0] in_heap_q;

	logic [1:0] func_q;
	logic [7:0] handle_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic hok_q;
	logic [AW-1:0] hid_q;
	logic [AW-1:0] pos_q;     // current position of the moving element
	logic [AW-1:0] mh_q;      // handle of moving element
	logic [KEY_WIDTH-1:0] mk_q;
	logic [AW-1:0] oh_q;      // parent handle during sift up
	logic [AW-1:0] lh_q;      // left child handle
	logic [KEY_WIDTH-1:0] lk_q;
	logic [AW-1:0] rhd_q;     // right child handle
	logic rchk_q;             // right child present

	logic [31:0] rk_q;
	logic [7:0] rh_q;
	logic [2:0] st_q;
	logic ov_q;
	logic [31:0] ork_q;
	logic [7:0] orh_q;
	logic [2:0] ost_q;
	logic [8:0] ocnt_q;

	logic hwe, ewe;
	logic [AW-1:0] hwa, hwd, hra, hrd, ewa, era;
	logic [EW-1:0] ewd, erd;
	logic [KEY_WIDTH-1:0] erk;
	logic [AW-1:0] erp;

	imh_heap_mem #(.DEPTH(CAPACITY), .AW(AW)) u_heap (
		.clk(clk), .we(hwe), .waddr(hwa), .wdata(hwd), .raddr(hra), .rdata(hrd));
	imh_elem_mem #(.DEPTH(CAPACITY), .AW(AW), .DW(EW)) u_elem (
		.clk(clk), .we(ewe), .waddr(ewa), .wdata(ewd), .raddr(era), .rdata(erd));

	assign erk = erd[EW-1:AW];
	assign erp = erd[AW-1:0];

	function automatic logic kless(input logic [KEY_WIDTH-1:0] a,
		input logic [KEY_WIDTH-1:0] b, input logic s);
		logic [KEY_WIDTH-1:0] m;
		m = '0;
		m[KEY_WIDTH-1] = s;
		return (a ^ m) < (b ^ m);
	endfunction

	logic [31:0] lim;
	logic [CW:0] lchild, rchild;
	logic [AW-1:0] parent;
	logic in_acc, out_acc, load_out;
	logic ubet, lbet, rbet;
	logic [2:0] chk_st;

	assign lim = (32'(cap_q) > CAPACITY) ? 32'(CAPACITY) : 32'(cap_q);
	assign lchild = (CW + 1)'({pos_q, 1'b1});
	assign rchild = lchild + (CW + 1)'(1);
	assign parent = AW'((pos_q - AW'(1)) >> 1);
	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_acc = ov_q && out_ready;
	assign load_out = (state_q == S_DONE) && (!ov_q || out_ready);

	assign ubet = kless(mk_q, erk, sgn_q);
	assign lbet = kless(lk_q, mk_q, sgn_q);
	assign rbet = rchk_q && kless(erk, lbet ? lk_q : mk_q, sgn_q);

	assign out_valid     = ov_q;
	assign result_key    = ork_q;
	assign result_handle = orh_q;
	assign status        = ost_q;
	assign element_count = ocnt_q;

	// status of the word under check
	always_comb begin
		case (func_q)
			imh_pkg::FUNC_INSERT: begin
				if (!hok_q || in_heap_q[hid_q]) begin
					chk_st = imh_pkg::ST_BAD_HANDLE;
				end else if (32'(count_q) >= lim) begin
					chk_st = imh_pkg::ST_FULL;
				end else begin
					chk_st = imh_pkg::ST_OK;
				end
			end
			imh_pkg::FUNC_DECREASE: begin
				if (!hok_q || !in_heap_q[hid_q]) begin
					chk_st = imh_pkg::ST_BAD_HANDLE;
				end else if (kless(erk, key_q, sgn_q)) begin
					chk_st = imh_pkg::ST_LARGER;
				end else begin
					chk_st = imh_pkg::ST_OK;
				end
			end
			default: begin
				chk_st = (count_q == '0) ? imh_pkg::ST_EMPTY : imh_pkg::ST_OK;
			end
		endcase
	end

	// memory port steering per state
	always_comb begin
		hwe = 1'b0; hwa = pos_q; hwd = mh_q;
		ewe = 1'b0; ewa = mh_q; ewd = {mk_q, pos_q};
		hra = pos_q; era = hid_q;
		case (state_q)
			S_RD: begin
				hra = '0;
				era = hid_q;
			end
			S_CHK: begin
				// root key and last handle
				era = hrd;
				hra = AW'(count_q - CW'(1));
			end
			S_X1: begin
				era = hrd;
			end
			S_U1: begin
				hra = parent;
			end
			S_U2: begin
				era = hrd;
			end
			S_U3: begin
				// move parent down into the hole
				if (ubet) begin
					hwe = 1'b1; hwa = pos_q; hwd = oh_q;
					ewe = 1'b1; ewa = oh_q; ewd = {erk, pos_q};
				end
			end
			S_D1: begin
				hra = AW'(lchild);
			end
			S_D2: begin
				era = hrd;
				hra = AW'(rchild);
			end
			S_D3: begin
				era = hrd;
			end
			S_D4: begin
				// move the smaller child up into the hole
				if (rbet) begin
					hwe = 1'b1; hwa = pos_q; hwd = rhd_q;
					ewe = 1'b1; ewa = rhd_q; ewd = {erk, pos_q};
				end else if (lbet) begin
					hwe = 1'b1; hwa = pos_q; hwd = lh_q;
					ewe = 1'b1; ewa = lh_q; ewd = {lk_q, pos_q};
				end
			end
			S_F: begin
				// place moving element
				hwe = 1'b1;
				ewe = 1'b1;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cap_q     <= 9'd256;
			sgn_q     <= 1'b0;
			count_q   <= '0;
			in_heap_q <= '0;
			ov_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == imh_pkg::REG_CAPACITY_LIMIT) begin
					cap_q <= cfg_data;
				end else if (cfg_index == imh_pkg::REG_SIGNED_KEYS) begin
					sgn_q <= cfg_data[0];
				end
			end
			// load or drop the output word
			if (load_out) begin
				ov_q   <= 1'b1;
				ork_q  <= rk_q;
				orh_q  <= rh_q;
				ost_q  <= st_q;
				ocnt_q <= 9'(count_q);
			end else if (out_acc) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						func_q   <= func;
						handle_q <= handle;
						key_q    <= KEY_WIDTH'(key);
						hok_q    <= (32'(handle) < CAPACITY);
						hid_q    <= AW'(handle);
						state_q  <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					st_q <= chk_st;
					if (chk_st != imh_pkg::ST_OK) begin
						rk_q <= '0; rh_q <= '0;
						state_q <= S_DONE;
					end else begin
						case (func_q)
							imh_pkg::FUNC_INSERT: begin
								in_heap_q[hid_q] <= 1'b1;
								count_q <= count_q + CW'(1);
								mh_q <= hid_q; mk_q <= key_q;
								pos_q <= AW'(count_q);
								rk_q <= 32'(key_q[KL-1:0]); rh_q <= handle_q;
								state_q <= S_U1;
							end
							imh_pkg::FUNC_DECREASE: begin
								mh_q <= hid_q; mk_q <= key_q;
								pos_q <= erp;
								rk_q <= 32'(key_q[KL-1:0]); rh_q <= handle_q;
								state_q <= S_U1;
							end
							default: begin
								// extract or peek: root handle in hrd
								rh_q <= 8'(hrd);
								hid_q <= hrd;
								state_q <= S_X1;
							end
						endcase
					end
				end
				S_X1: begin
					// root key ready; extract also has the last handle
					rk_q <= 32'(erk[KL-1:0]);
					if (func_q == imh_pkg::FUNC_PEEK) begin
						state_q <= S_DONE;
					end else begin
						in_heap_q[hid_q] <= 1'b0;
						count_q <= count_q - CW'(1);
						if (count_q == CW'(1)) begin
							state_q <= S_DONE;
						end else begin
							mh_q <= hrd;
							pos_q <= '0;
							state_q <= S_X2;
						end
					end
				end
				S_X2: begin
					mk_q <= erk;
					state_q <= S_D1;
				end
				S_U1: begin
					state_q <= (pos_q == '0) ? S_F : S_U2;
				end
				S_U2: begin
					oh_q <= hrd;
					state_q <= S_U3;
				end
				S_U3: begin
					if (ubet) begin
						pos_q <= parent;
						state_q <= S_U1;
					end else begin
						state_q <= S_F;
					end
				end
				S_D1: begin
					if (lchild >= (CW + 1)'(count_q)) begin
						state_q <= S_F;
					end else begin
						rchk_q <= (rchild < (CW + 1)'(count_q));
						state_q <= S_D2;
					end
				end
				S_D2: begin
					lh_q <= hrd;
					state_q <= S_D3;
				end
				S_D3: begin
					lk_q <= erk;
					rhd_q <= hrd;
					state_q <= S_D4;
				end
				S_D4: begin
					if (rbet) begin
						pos_q <= AW'(rchild);
						state_q <= S_D1;
					end else if (lbet) begin
						pos_q <= AW'(lchild);
						state_q <= S_D1;
					end else begin
						state_q <= S_F;
					end
				end
				S_F: state_q <= S_DONE;
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q));
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_key) &&
		$stable(result_handle) && $stable(status) && $stable(element_count));
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY);
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= imh_pkg::ST_LARGER);
`endif
endmodule

/* hw/rtl/imh_heap_mem.sv */
// Heap-order memory: heap position to handle, one write and one read port.
// Depends on nothing; instanced by indexed_min_heap.
module imh_heap_mem #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);
	logic [AW-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hw/rtl/imh_elem_mem.sv */
// Per-handle memory: key and heap position stored together per handle.
// Depends on nothing; instanced by indexed_min_heap.
module imh_elem_mem #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8,
	parameter int unsigned DW    = 40
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
